// ----- hdl/pulse_width_bit_time_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Pulse width bit time decoder assertion macros
// Concurrent assertion forms used by the decoder result register.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_BIT_TIME_DECODER_UNIT_ASSERT_SVH
`define PULSE_WIDTH_BIT_TIME_DECODER_UNIT_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define PWBTD_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define PWBTD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hdl/pwbtd_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse width bit time decoder package
// Constants and the result request type shared by the decoder modules.
// ----------------------------------------------------------------------------
package pwbtd_pkg;

  localparam int MaxDurationsDefault = 131;
  localparam int StartSkip = 2;
  localparam int GroupLen = 16;
  localparam int ByteWidth = 8;
  localparam int IndexWidth = 3;
  localparam int TotalWidth = 4;
  localparam int CountWidth = 8;

  typedef struct packed {
    logic                  has_result;
    logic [ByteWidth-1:0]  byte_value;
    logic                  byte_valid;
    logic [IndexWidth-1:0] byte_index;
    logic                  frame_end;
    logic [TotalWidth-1:0] byte_total;
  } result_t;

endpackage

// ----- hdl/pwbtd_decode.sv -----
// ----------------------------------------------------------------------------
// Pulse width bit time decoder, decode stage
// Frame state and the per-duration compare, shift and byte completion logic.
// ----------------------------------------------------------------------------
module pwbtd_decode #(
  parameter int MAX_DURATIONS = pwbtd_pkg::MaxDurationsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [pwbtd_pkg::ByteWidth-1:0] bit_time,
  input  logic                           frame_last,
  output pwbtd_pkg::result_t             result
);
  import pwbtd_pkg::*;

  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_DURATIONS);
  localparam logic [CountWidth-1:0] SkipCount = CountWidth'(StartSkip);
  localparam logic [CountWidth-1:0] GroupMask = CountWidth'(GroupLen - 1);

  logic [CountWidth-1:0] duration_count, duration_count_next;
  logic [ByteWidth-1:0]  held_low_time, held_low_time_next;
  logic [ByteWidth-1:0]  bit_shift, bit_shift_next;
  logic [TotalWidth-1:0] bytes_done, bytes_done_next;
  logic [CountWidth-1:0] q;
  logic [ByteWidth-1:0]  shifted;
  logic                  got_byte;

  assign q = duration_count - SkipCount;
  assign shifted = {bit_shift[ByteWidth-2:0], (held_low_time > bit_time)};

  always_comb begin
    duration_count_next = duration_count;
    held_low_time_next = held_low_time;
    bit_shift_next = bit_shift;
    bytes_done_next = bytes_done;
    got_byte = 1'b0;
    result = '0;
    if (duration_count < MaxCount) begin
      duration_count_next = duration_count + 1'b1;
      if (duration_count >= SkipCount) begin
        if (!q[0]) begin
          held_low_time_next = bit_time;
        end else if ((q & GroupMask) == GroupMask) begin
          got_byte = 1'b1;
          result.byte_value = shifted;
          result.byte_index = bytes_done[IndexWidth-1:0];
          bytes_done_next = bytes_done + 1'b1;
          bit_shift_next = '0;
        end else begin
          bit_shift_next = shifted;
        end
      end
    end
    result.has_result = got_byte || frame_last;
    result.byte_valid = got_byte;
    result.frame_end = frame_last;
    if (frame_last) begin
      result.byte_total = bytes_done_next;
      duration_count_next = '0;
      held_low_time_next = '0;
      bit_shift_next = '0;
      bytes_done_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_count <= '0;
      held_low_time <= '0;
      bit_shift <= '0;
      bytes_done <= '0;
    end else if (accept) begin
      duration_count <= duration_count_next;
      held_low_time <= held_low_time_next;
      bit_shift <= bit_shift_next;
      bytes_done <= bytes_done_next;
    end
  end

endmodule

// ----- hdl/pwbtd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Pulse width bit time decoder, result register
// Holds one result request and parts the input side from the output stall.
// ----------------------------------------------------------------------------
module pwbtd_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pwbtd_pkg::result_t               result,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pwbtd_pkg::ByteWidth-1:0]  byte_value,
  output logic                             byte_valid,
  output logic [pwbtd_pkg::IndexWidth-1:0] byte_index,
  output logic                             frame_end,
  output logic [pwbtd_pkg::TotalWidth-1:0] byte_total
);
  import pwbtd_pkg::*;

  `include "pulse_width_bit_time_decoder_unit_assert.svh"

  logic load;

  assign in_stall = out_valid && out_stall;
  assign load = in_valid && !in_stall && result.has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_value <= result.byte_value;
      byte_valid <= result.byte_valid;
      byte_index <= result.byte_index;
      frame_end <= result.frame_end;
      byte_total <= result.byte_total;
    end
  end

  `PWBTD_ASSERT_NOW(a_result_has_content, out_valid, byte_valid || frame_end, "empty result")
  `PWBTD_ASSERT_NOW(a_total_only_at_end, out_valid && !frame_end, byte_total == '0, "stray total")
  `PWBTD_ASSERT_NEXT(a_load_shows, load, out_valid, "loaded result not shown")

endmodule

// ----- hdl/pulse_width_bit_time_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// Pulse width bit time decoder unit
// Decodes a frame of measured bus phase durations into data bytes.
// ----------------------------------------------------------------------------
// The block accepts one duration request per cycle unless stalled. Each
// duration updates the frame state in the same cycle it is accepted, and any
// byte or frame end result appears on the output in the next cycle from a
// single result register. Input is stalled only while that register holds a
// result the output stalls; with no output stall, one duration per cycle.
module pulse_width_bit_time_decoder_unit #(
  parameter int MAX_DURATIONS = pwbtd_pkg::MaxDurationsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pwbtd_pkg::ByteWidth-1:0]  bit_time,
  input  logic                             frame_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pwbtd_pkg::ByteWidth-1:0]  byte_value,
  output logic                             byte_valid,
  output logic [pwbtd_pkg::IndexWidth-1:0] byte_index,
  output logic                             frame_end,
  output logic [pwbtd_pkg::TotalWidth-1:0] byte_total
);
  import pwbtd_pkg::*;

  result_t result;
  logic    accept;

  assign accept = in_valid && !in_stall;

  pwbtd_decode #(
    .MAX_DURATIONS(MAX_DURATIONS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .bit_time  (bit_time),
    .frame_last(frame_last),
    .result    (result)
  );

  pwbtd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_value(byte_value),
    .byte_valid(byte_valid),
    .byte_index(byte_index),
    .frame_end (frame_end),
    .byte_total(byte_total)
  );

endmodule
